/* rtl/abpp_pkg.sv */
// ----------------------------------------------------------------------------
// abpp_pkg
// Shared widths, register indexes and fixed pixel formats of the alpha blend
// pixel packer.
// ----------------------------------------------------------------------------
`default_nettype none

package abpp_pkg;

  // field widths
  localparam int unsigned CompW    = 8;
  localparam int unsigned PixW     = 32;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned DepthW   = 6;
  localparam int unsigned BlendW   = 2 * CompW;
  localparam int unsigned ShW      = 5;
  localparam int unsigned RunW     = 6;
  localparam int unsigned NumCh    = 3;

  // lane order inside the datapath
  localparam int unsigned ChRed   = 0;
  localparam int unsigned ChGreen = 1;
  localparam int unsigned ChBlue  = 2;

  // full scale of one color component
  localparam logic [CompW-1:0] CompMax = 8'hFF;

  // rounding term and reciprocal of 255: floor(y / 255) == (y * Recip255) >> 39
  localparam logic [PixW-1:0]  RoundHalf  = 32'd127;
  localparam logic [PixW-1:0]  Recip255   = 32'h8080_8081;
  localparam int unsigned      RecipShift = 39;
  localparam int unsigned      QuotW      = 2 * PixW - RecipShift;

  // fallback formats picked by color depth
  localparam logic [DepthW-1:0] Depth15 = 6'd15;
  localparam logic [DepthW-1:0] Depth16 = 6'd16;

  localparam logic [PixW-1:0] Mask555Red   = 32'h0000_7C00;
  localparam logic [PixW-1:0] Mask555Green = 32'h0000_03E0;
  localparam logic [PixW-1:0] Mask555Blue  = 32'h0000_001F;
  localparam logic [PixW-1:0] Mask565Red   = 32'h0000_F800;
  localparam logic [PixW-1:0] Mask565Green = 32'h0000_07E0;
  localparam logic [PixW-1:0] Mask565Blue  = 32'h0000_001F;
  localparam logic [PixW-1:0] Mask888Red   = 32'h00FF_0000;
  localparam logic [PixW-1:0] Mask888Green = 32'h0000_FF00;
  localparam logic [PixW-1:0] Mask888Blue  = 32'h0000_00FF;

  // reset value of the color depth register
  localparam logic [DepthW-1:0] DepthReset = 6'd32;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_BG_RED     = 3'd0,
    REG_BG_GREEN   = 3'd1,
    REG_BG_BLUE    = 3'd2,
    REG_MASK_RED   = 3'd3,
    REG_MASK_GREEN = 3'd4,
    REG_MASK_BLUE  = 3'd5,
    REG_DEPTH      = 3'd6
  } abpp_reg_t;

endpackage

`default_nettype wire

/* rtl/abpp_src_if.sv */
// ----------------------------------------------------------------------------
// abpp_src_if
// Source pixel channel: one BGRA pixel per request, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface abpp_src_if;
  import abpp_pkg::*;

  logic             valid;
  logic             ready;
  logic [CompW-1:0] src_blue;
  logic [CompW-1:0] src_green;
  logic [CompW-1:0] src_red;
  logic [CompW-1:0] src_alpha;

  modport source (
    output valid, src_blue, src_green, src_red, src_alpha,
    input  ready
  );

  modport sink (
    input  valid, src_blue, src_green, src_red, src_alpha,
    output ready
  );

endinterface

`default_nettype wire

/* rtl/abpp_pix_if.sv */
// ----------------------------------------------------------------------------
// abpp_pix_if
// Packed pixel channel: one display pixel word per request, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface abpp_pix_if;
  import abpp_pkg::*;

  logic            valid;
  logic            ready;
  logic [PixW-1:0] packed_pixel;

  modport source (
    output valid, packed_pixel,
    input  ready
  );

  modport sink (
    input  valid, packed_pixel,
    output ready
  );

endinterface

`default_nettype wire

/* rtl/alpha_blend_pixel_packer_top.sv */
// ----------------------------------------------------------------------------
// alpha_blend_pixel_packer_top
// Blends a BGRA pixel over a background color and packs it into a display
// pixel word through a five stage pipeline.
// ----------------------------------------------------------------------------
// The block takes one source pixel per clock while the output side does not
// stall and returns one packed pixel for each, in order. Throughput is one
// pixel per clock without stalls, set by the five register stages: blend
// products and mask shift, divide by 255 and field width, field scaling
// multiply, reciprocal multiply for the rounding divide, and the final shift
// and merge. Each stage holds its request while the next one is full, so back
// pressure on the output travels back to src.ready without losing or
// repeating a pixel. Background color, field masks and color depth are
// written through the cfg port; the user must write them only while no pixel
// is in flight, which the block itself does not enforce. If any mask is zero
// the fixed 5:5:5, 5:6:5 or 8:8:8 format picked by the color depth is used.
`default_nettype none

module alpha_blend_pixel_packer_top (
  input  logic                          clk,
  input  logic                          rst,
  abpp_src_if.sink                      src,
  abpp_pix_if.source                    pix,
  input  logic                          cfg_we,
  input  logic [abpp_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [abpp_pkg::CfgDataW-1:0] cfg_data
);
  import abpp_pkg::*;

  // trailing zero count, PixW when the word is zero
  function automatic logic [RunW-1:0] trail_zeros(input logic [PixW-1:0] word);
    logic [RunW-1:0] cnt;
    cnt = RunW'(PixW);
    for (int i = PixW - 1; i >= 0; i--) begin
      if (word[i]) begin
        cnt = RunW'(i);
      end
    end
    return cnt;
  endfunction

  // configuration registers
  logic [CompW-1:0]  bg_red;
  logic [CompW-1:0]  bg_green;
  logic [CompW-1:0]  bg_blue;
  logic [PixW-1:0]   mask_red;
  logic [PixW-1:0]   mask_green;
  logic [PixW-1:0]   mask_blue;
  logic [DepthW-1:0] color_depth;

  // selected masks and per lane operands
  logic                             any_mask_zero;
  logic [NumCh-1:0][PixW-1:0]       eff_mask;
  logic [NumCh-1:0][CompW-1:0]      src_comp;
  logic [NumCh-1:0][CompW-1:0]      bg_comp;

  // pipeline handshake
  logic s1_valid, s2_valid, s3_valid, s4_valid, s5_valid;
  logic s1_rdy, s2_rdy, s3_rdy, s4_rdy, s5_rdy;

  // stage payloads
  logic [NumCh-1:0][BlendW-1:0] s1_x;
  logic [NumCh-1:0][PixW-1:0]   s1_mask;
  logic [NumCh-1:0][ShW-1:0]    s1_sh;
  logic [NumCh-1:0][CompW-1:0]  s2_v;
  logic [NumCh-1:0][PixW-1:0]   s2_top;
  logic [NumCh-1:0][ShW-1:0]    s2_sh;
  logic [NumCh-1:0][PixW-1:0]   s3_y;
  logic [NumCh-1:0][ShW-1:0]    s3_sh;
  logic [NumCh-1:0][QuotW-1:0]  s4_q;
  logic [NumCh-1:0][ShW-1:0]    s4_sh;
  logic [PixW-1:0]              s5_pixel;

  // stage next values
  logic [NumCh-1:0][BlendW-1:0] s1_x_next;
  logic [NumCh-1:0][ShW-1:0]    s1_sh_next;
  logic [NumCh-1:0][CompW-1:0]  blend_q0;
  logic [NumCh-1:0][8:0]        blend_rem;
  logic [NumCh-1:0][CompW-1:0]  s2_v_next;
  logic [NumCh-1:0][PixW-1:0]   field_w;
  logic [NumCh-1:0][RunW-1:0]   field_run;
  logic [NumCh-1:0][PixW-1:0]   s2_top_next;
  logic [NumCh-1:0][PixW-1:0]   s3_y_next;
  logic [NumCh-1:0][2*PixW-1:0] recip_prod;
  logic [NumCh-1:0][QuotW-1:0]  s4_q_next;
  logic [PixW-1:0]              s5_pixel_next;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      bg_red      <= '0;
      bg_green    <= '0;
      bg_blue     <= '0;
      mask_red    <= '0;
      mask_green  <= '0;
      mask_blue   <= '0;
      color_depth <= DepthReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BG_RED:     bg_red      <= cfg_data[CompW-1:0];
        REG_BG_GREEN:   bg_green    <= cfg_data[CompW-1:0];
        REG_BG_BLUE:    bg_blue     <= cfg_data[CompW-1:0];
        REG_MASK_RED:   mask_red    <= cfg_data[PixW-1:0];
        REG_MASK_GREEN: mask_green  <= cfg_data[PixW-1:0];
        REG_MASK_BLUE:  mask_blue   <= cfg_data[PixW-1:0];
        REG_DEPTH:      color_depth <= cfg_data[DepthW-1:0];
        default: ;
      endcase
    end
  end

  // mask selection with fixed format fallback
  always_comb begin
    any_mask_zero = (mask_red == '0) || (mask_green == '0) || (mask_blue == '0);
    priority if (!any_mask_zero) begin
      eff_mask[ChRed]   = mask_red;
      eff_mask[ChGreen] = mask_green;
      eff_mask[ChBlue]  = mask_blue;
    end else if (color_depth == Depth15) begin
      eff_mask[ChRed]   = Mask555Red;
      eff_mask[ChGreen] = Mask555Green;
      eff_mask[ChBlue]  = Mask555Blue;
    end else if (color_depth == Depth16) begin
      eff_mask[ChRed]   = Mask565Red;
      eff_mask[ChGreen] = Mask565Green;
      eff_mask[ChBlue]  = Mask565Blue;
    end else begin
      eff_mask[ChRed]   = Mask888Red;
      eff_mask[ChGreen] = Mask888Green;
      eff_mask[ChBlue]  = Mask888Blue;
    end
  end

  // lane operands
  always_comb begin
    src_comp[ChRed]   = src.src_red;
    src_comp[ChGreen] = src.src_green;
    src_comp[ChBlue]  = src.src_blue;
    bg_comp[ChRed]    = bg_red;
    bg_comp[ChGreen]  = bg_green;
    bg_comp[ChBlue]   = bg_blue;
  end

  // stall chain: a stage moves when it is empty or the next one moves
  assign s5_rdy    = !s5_valid || pix.ready;
  assign s4_rdy    = !s4_valid || s5_rdy;
  assign s3_rdy    = !s3_valid || s4_rdy;
  assign s2_rdy    = !s2_valid || s3_rdy;
  assign s1_rdy    = !s1_valid || s2_rdy;
  assign src.ready = s1_rdy;

  // stage 1 logic: blend numerator and field shift
  always_comb begin
    for (int c = 0; c < NumCh; c++) begin
      s1_x_next[c]  = BlendW'(src_comp[c]) * BlendW'(src.src_alpha)
                    + BlendW'(bg_comp[c]) * BlendW'(CompMax - src.src_alpha);
      s1_sh_next[c] = ShW'(trail_zeros(eff_mask[c]));
    end
  end

  // stage 2 logic: divide by 255 and field width
  always_comb begin
    for (int c = 0; c < NumCh; c++) begin
      blend_q0[c]    = CompW'((s1_x[c] + (s1_x[c] >> CompW)) >> CompW);
      blend_rem[c]   = 9'(s1_x[c] - BlendW'(blend_q0[c]) * BlendW'(CompMax));
      s2_v_next[c]   = (blend_rem[c] >= 9'(CompMax)) ? blend_q0[c] + 1'b1 : blend_q0[c];
      field_w[c]     = s1_mask[c] >> s1_sh[c];
      field_run[c]   = trail_zeros(~field_w[c]);
      s2_top_next[c] = (field_run[c] >= RunW'(PixW - 1)) ? '1
                     : (PixW'(1) << field_run[c]) - PixW'(1);
    end
  end

  // stage 3 logic: scale to field range, wrapping at 32 bits
  always_comb begin
    for (int c = 0; c < NumCh; c++) begin
      s3_y_next[c] = PixW'(PixW'(s2_v[c]) * s2_top[c]) + RoundHalf;
    end
  end

  // stage 4 logic: reciprocal multiply for the divide by 255
  always_comb begin
    for (int c = 0; c < NumCh; c++) begin
      recip_prod[c] = {{PixW{1'b0}}, s3_y[c]} * {{PixW{1'b0}}, Recip255};
      s4_q_next[c]  = recip_prod[c][2*PixW-1:RecipShift];
    end
  end

  // stage 5 logic: shift fields into place and merge
  always_comb begin
    s5_pixel_next = '0;
    for (int c = 0; c < NumCh; c++) begin
      s5_pixel_next = s5_pixel_next | (PixW'(s4_q[c]) << s4_sh[c]);
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
    end else begin
      if (s1_rdy) s1_valid <= src.valid;
      if (s2_rdy) s2_valid <= s1_valid;
      if (s3_rdy) s3_valid <= s2_valid;
      if (s4_rdy) s4_valid <= s3_valid;
      if (s5_rdy) s5_valid <= s4_valid;
    end
  end

  // stage payload registers
  always_ff @(posedge clk) begin
    if (s1_rdy) begin
      s1_x    <= s1_x_next;
      s1_mask <= eff_mask;
      s1_sh   <= s1_sh_next;
    end
    if (s2_rdy) begin
      s2_v   <= s2_v_next;
      s2_top <= s2_top_next;
      s2_sh  <= s1_sh;
    end
    if (s3_rdy) begin
      s3_y  <= s3_y_next;
      s3_sh <= s2_sh;
    end
    if (s4_rdy) begin
      s4_q  <= s4_q_next;
      s4_sh <= s3_sh;
    end
    if (s5_rdy) begin
      s5_pixel <= s5_pixel_next;
    end
  end

  assign pix.valid        = s5_valid;
  assign pix.packed_pixel = s5_pixel;

`ifndef ASSERT_OFF
  // a stalled blend stage keeps its request
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s2_rdy |=> s1_valid && $stable(s1_x))
    else $error("blend stage lost or changed a stalled request");

  // one correction step is enough for the divide by 255
  a_blend_rem: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (blend_rem[ChRed] < 9'd510) && (blend_rem[ChGreen] < 9'd510)
                 && (blend_rem[ChBlue] < 9'd510))
    else $error("blend remainder out of range");

  // a fully opaque pixel carries no background term
  a_opaque: assert property (@(posedge clk) disable iff (rst)
    src.valid && src.ready && (src.src_alpha == CompMax)
    |=> s1_x[ChRed] == BlendW'($past(src.src_red)) * BlendW'(CompMax))
    else $error("opaque blend picked up background");

  // the fallback never leaves a lane without a field
  a_mask_nonzero: assert property (@(posedge clk) disable iff (rst)
    (eff_mask[ChRed] != '0) && (eff_mask[ChGreen] != '0) && (eff_mask[ChBlue] != '0))
    else $error("selected field mask is zero");

  // an output request only comes out of the last pipeline stage
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(pix.valid) |-> $past(s4_valid))
    else $error("output request without a pixel in the pipeline");
`endif

endmodule

`default_nettype wire
